FILE: design/rtpsri_pkg.sv
`default_nettype none

package rtpsri_pkg;

   typedef logic [1:0]  mode_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [16:0] seq_cnt_type;

   localparam mode_type MODE_HDR = 2'd0;
   localparam mode_type MODE_SPS = 2'd1;
   localparam mode_type MODE_PPS = 2'd2;

   localparam csr_index_type CSR_SPS_LEN = 2'd0;
   localparam csr_index_type CSR_PPS_LEN = 2'd1;
   localparam csr_index_type CSR_PT      = 2'd2;

   localparam logic [6:0]  PT_RESET   = 7'd102;
   localparam seq_cnt_type SEQ_MOD    = 17'h1FFFF;
   // 2^32 mod (2^17 - 1): folds a 32-bit negative wrap back into the counter range
   localparam seq_cnt_type SEQ_WRAP   = 17'd32768;

   localparam logic [4:0] NAL_FU_A    = 5'd28;
   localparam logic [4:0] NAL_IDR     = 5'd5;
   localparam logic [7:0] STAP_A_HDR  = 8'h38;

   localparam int RTP_HDR_BYTES    = 12;
   localparam int STAP_FIXED_BYTES = 17;

endpackage

`default_nettype wire

FILE: design/rtpsri_ram.sv
`default_nettype none

module rtpsri_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 24,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/rtp_h264_seq_rewrite_param_inject.sv
// Load requests (SPS/PPS bytes) and ignored modes complete in the cycle they are accepted.
// Header request: S_MOD updates the counter, then S_HDR registers the result; the next
// request is taken back in S_IDLE. With injection, S_INJ sends one aggregation byte per cycle
// while the output is not stalled (17 + sps + pps bytes, 57 max at default sizes) ahead
// of the header result; table bytes come from each parameter-set RAM's single read port, prefetched.
// Reset (sync) clears control, counter, prev sequence, SPS/PPS lengths; PT to 102; tables unknown.
`default_nettype none

module rtp_h264_seq_rewrite_param_inject #(
   parameter int MAX_SPS_BYTES = 24,
   parameter int MAX_PPS_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_wdata,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [4:0]  req_load_index,
   input  wire logic [7:0]  req_load_byte,
   input  wire logic [7:0]  req_hdr_byte0,
   input  wire logic [7:0]  req_hdr_byte1,
   input  wire logic [15:0] req_in_seq,
   input  wire logic [31:0] req_rtp_timestamp,
   input  wire logic [31:0] req_ssrc_id,
   input  wire logic [7:0]  req_fu_indicator,
   input  wire logic [7:0]  req_fu_header,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_out_byte1,
   output logic [15:0]      rsp_out_seq,
   output logic [7:0]       rsp_inject_byte,
   output logic [5:0]       rsp_inject_len,
   output logic             rsp_last_of_run
);

   localparam int PKT_MAX = rtpsri_pkg::STAP_FIXED_BYTES + MAX_SPS_BYTES + MAX_PPS_BYTES;
   localparam int CNT_W   = $clog2(PKT_MAX + 1);
   localparam int SPS_AW  = (MAX_SPS_BYTES > 1) ? $clog2(MAX_SPS_BYTES) : 1;
   localparam int PPS_AW  = (MAX_PPS_BYTES > 1) ? $clog2(MAX_PPS_BYTES) : 1;

   localparam logic [CNT_W-1:0] POS_STAP    = CNT_W'(rtpsri_pkg::RTP_HDR_BYTES);
   localparam logic [CNT_W-1:0] POS_SPS_HI  = CNT_W'(rtpsri_pkg::RTP_HDR_BYTES + 1);
   localparam logic [CNT_W-1:0] POS_SPS_LEN = CNT_W'(rtpsri_pkg::RTP_HDR_BYTES + 2);
   localparam logic [CNT_W-1:0] POS_SPS     = CNT_W'(rtpsri_pkg::RTP_HDR_BYTES + 3);
   localparam logic [CNT_W-1:0] POS_PPS     = CNT_W'(rtpsri_pkg::RTP_HDR_BYTES + 5);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MOD  = 2'd1;
   localparam logic [1:0] S_INJ  = 2'd2;
   localparam logic [1:0] S_HDR  = 2'd3;

   logic [1:0]              state_ff, state_in;
   rtpsri_pkg::seq_cnt_type counter_ff, counter_in;
   logic [15:0]             prev_seq_ff, prev_seq_in;
   logic [18:0]             sum_ff, sum_in;
   logic                    inj_ff, inj_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        len_ff, len_in;
   logic [4:0]              ns_ff, ns_in;
   logic [4:0]              np_ff, np_in;

   logic [4:0]              sps_len_ff;
   logic [4:0]              pps_len_ff;
   logic [6:0]              pt_ff;

   logic [7:0]              b0_ff;
   logic [7:0]              nb1_ff;
   logic [31:0]             ts_ff;
   logic [31:0]             ss_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [7:0]              rsp_out_byte1_ff, rsp_out_byte1_in;
   logic [15:0]             rsp_out_seq_ff, rsp_out_seq_in;
   logic [7:0]              rsp_inject_byte_ff, rsp_inject_byte_in;
   logic [5:0]              rsp_inject_len_ff, rsp_inject_len_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_accept;
   logic                    hdr_accept;
   logic                    out_free;
   logic [15:0]             prev_eff;
   logic [18:0]             wrap_sum;
   rtpsri_pkg::seq_cnt_type counter_red;
   logic [7:0]              hdr_bytes [12];
   logic [7:0]              inj_byte;
   logic [CNT_W-1:0]        sps_end;

   logic                    sps_wr_en;
   logic                    pps_wr_en;
   logic [SPS_AW-1:0]       sps_rd_addr;
   logic [PPS_AW-1:0]       pps_rd_addr;
   logic [7:0]              sps_rd_data;
   logic [7:0]              pps_rd_data;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign hdr_accept = req_accept && (req_mode == rtpsri_pkg::MODE_HDR);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign sps_wr_en = req_accept && (req_mode == rtpsri_pkg::MODE_SPS)
                      && (int'(req_load_index) < MAX_SPS_BYTES);
   assign pps_wr_en = req_accept && (req_mode == rtpsri_pkg::MODE_PPS)
                      && (int'(req_load_index) < MAX_PPS_BYTES);

   // read address follows next position so data lines up with pos_ff
   assign sps_rd_addr = SPS_AW'(pos_in - POS_SPS);
   assign pps_rd_addr = PPS_AW'(pos_in - POS_PPS - CNT_W'(ns_ff));

   rtpsri_ram #(.WIDTH(8), .DEPTH(MAX_SPS_BYTES)) u_sps_ram (
      .clock   (clock),
      .wr_en   (sps_wr_en),
      .wr_addr (req_load_index[SPS_AW-1:0]),
      .wr_data (req_load_byte),
      .rd_addr (sps_rd_addr),
      .rd_data (sps_rd_data)
   );

   rtpsri_ram #(.WIDTH(8), .DEPTH(MAX_PPS_BYTES)) u_pps_ram (
      .clock   (clock),
      .wr_en   (pps_wr_en),
      .wr_addr (req_load_index[PPS_AW-1:0]),
      .wr_data (req_load_byte),
      .rd_addr (pps_rd_addr),
      .rd_data (pps_rd_data)
   );

   // sequence step, reduced modulo 2^17 - 1 with 32-bit wrap semantics
   assign prev_eff = (prev_seq_ff == 16'd0) ? req_in_seq : prev_seq_ff;
   assign wrap_sum = sum_ff + 19'(rtpsri_pkg::SEQ_WRAP);

   always_comb begin
      if (sum_ff[18]) begin
         counter_red = wrap_sum[18] ? 17'(wrap_sum + 19'(rtpsri_pkg::SEQ_MOD))
                                    : wrap_sum[16:0];
      end else begin
         counter_red = (sum_ff >= 19'(rtpsri_pkg::SEQ_MOD))
                       ? 17'(sum_ff - 19'(rtpsri_pkg::SEQ_MOD)) : sum_ff[16:0];
      end
   end

   assign hdr_bytes[0]  = b0_ff;
   assign hdr_bytes[1]  = nb1_ff;
   assign hdr_bytes[2]  = counter_ff[15:8];
   assign hdr_bytes[3]  = counter_ff[7:0];
   assign hdr_bytes[4]  = ts_ff[31:24];
   assign hdr_bytes[5]  = ts_ff[23:16];
   assign hdr_bytes[6]  = ts_ff[15:8];
   assign hdr_bytes[7]  = ts_ff[7:0];
   assign hdr_bytes[8]  = ss_ff[31:24];
   assign hdr_bytes[9]  = ss_ff[23:16];
   assign hdr_bytes[10] = ss_ff[15:8];
   assign hdr_bytes[11] = ss_ff[7:0];

   assign sps_end = POS_SPS + CNT_W'(ns_ff);

   always_comb begin
      priority if (pos_ff < POS_STAP) begin
         inj_byte = hdr_bytes[pos_ff[3:0]];
      end else if (pos_ff == POS_STAP) begin
         inj_byte = rtpsri_pkg::STAP_A_HDR;
      end else if (pos_ff == POS_SPS_HI) begin
         inj_byte = 8'd0;
      end else if (pos_ff == POS_SPS_LEN) begin
         inj_byte = 8'(ns_ff);
      end else if (pos_ff < sps_end) begin
         inj_byte = sps_rd_data;
      end else if (pos_ff == sps_end) begin
         inj_byte = 8'd0;
      end else if (pos_ff == sps_end + CNT_W'(1)) begin
         inj_byte = 8'(np_ff);
      end else begin
         inj_byte = pps_rd_data;
      end
   end

   always_comb begin
      state_in           = state_ff;
      counter_in         = counter_ff;
      prev_seq_in        = prev_seq_ff;
      sum_in             = sum_ff;
      inj_in             = inj_ff;
      pos_in             = pos_ff;
      len_in             = len_ff;
      ns_in              = ns_ff;
      np_in              = np_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_load           = 1'b0;
      rsp_kind_in        = 1'b0;
      rsp_out_byte1_in   = 8'd0;
      rsp_out_seq_in     = 16'd0;
      rsp_inject_byte_in = 8'd0;
      rsp_inject_len_in  = 6'd0;
      rsp_last_in        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (hdr_accept) begin
               sum_in      = 19'(counter_ff) + 19'(req_in_seq) - 19'(prev_eff);
               prev_seq_in = req_in_seq;
               inj_in      = (req_fu_indicator[4:0] == rtpsri_pkg::NAL_FU_A)
                             && (req_fu_header[4:0] == rtpsri_pkg::NAL_IDR)
                             && req_fu_header[7];
               ns_in       = (int'(sps_len_ff) > MAX_SPS_BYTES) ? 5'(MAX_SPS_BYTES)
                                                                : sps_len_ff;
               np_in       = (int'(pps_len_ff) > MAX_PPS_BYTES) ? 5'(MAX_PPS_BYTES)
                                                                : pps_len_ff;
               len_in      = CNT_W'(rtpsri_pkg::STAP_FIXED_BYTES) + CNT_W'(ns_in)
                             + CNT_W'(np_in);
               state_in    = S_MOD;
            end
         end
         S_MOD: begin
            counter_in = counter_red;
            pos_in     = '0;
            state_in   = inj_ff ? S_INJ : S_HDR;
         end
         S_INJ: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_load           = 1'b1;
               rsp_kind_in        = 1'b1;
               rsp_inject_byte_in = inj_byte;
               rsp_inject_len_in  = 6'(len_ff);
               pos_in             = pos_ff + CNT_W'(1);
               if (pos_ff == len_ff - CNT_W'(1)) begin
                  counter_in = counter_ff + 17'd1;
                  state_in   = S_HDR;
               end
            end
         end
         S_HDR: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_load          = 1'b1;
               rsp_out_byte1_in  = nb1_ff;
               rsp_out_seq_in    = counter_ff[15:0];
               rsp_inject_len_in = inj_ff ? 6'(len_ff) : 6'd0;
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         counter_ff   <= '0;
         prev_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         sps_len_ff   <= '0;
         pps_len_ff   <= '0;
         pt_ff        <= rtpsri_pkg::PT_RESET;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         prev_seq_ff  <= prev_seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               rtpsri_pkg::CSR_SPS_LEN: sps_len_ff <= csr_wdata[4:0];
               rtpsri_pkg::CSR_PPS_LEN: pps_len_ff <= csr_wdata[4:0];
               rtpsri_pkg::CSR_PT:      pt_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      inj_ff <= inj_in;
      pos_ff <= pos_in;
      len_ff <= len_in;
      ns_ff  <= ns_in;
      np_ff  <= np_in;
      if (hdr_accept) begin
         b0_ff  <= req_hdr_byte0;
         nb1_ff <= {req_hdr_byte1[7], pt_ff};
         ts_ff  <= req_rtp_timestamp;
         ss_ff  <= req_ssrc_id;
      end
      if (rsp_load) begin
         rsp_kind_ff        <= rsp_kind_in;
         rsp_out_byte1_ff   <= rsp_out_byte1_in;
         rsp_out_seq_ff     <= rsp_out_seq_in;
         rsp_inject_byte_ff <= rsp_inject_byte_in;
         rsp_inject_len_ff  <= rsp_inject_len_in;
         rsp_last_ff        <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_byte1   = rsp_out_byte1_ff;
   assign rsp_out_seq     = rsp_out_seq_ff;
   assign rsp_inject_byte = rsp_inject_byte_ff;
   assign rsp_inject_len  = rsp_inject_len_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

FILE: design/rtpsri_chk.sv
`default_nettype none

module rtpsri_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_mode,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_out_byte1,
   input wire logic [15:0] rsp_out_seq,
   input wire logic [7:0]  rsp_inject_byte,
   input wire logic [5:0]  rsp_inject_len,
   input wire logic        rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_inject_byte)
                                  && $stable(rsp_out_seq) && $stable(rsp_last_of_run)
                                  && $stable(rsp_out_byte1) && $stable(rsp_inject_len))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hdr_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == rtpsri_pkg::MODE_HDR) |=> !req_ready)
      else $error("request taken during header processing");

   a_last_is_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != rsp_last_of_run))
      else $error("last flag does not match header result");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind ? (rsp_out_byte1 == 8'd0 && rsp_out_seq == 16'd0)
                              : (rsp_inject_byte == 8'd0)))
      else $error("unused response field not zero");

endmodule

bind rtp_h264_seq_rewrite_param_inject rtpsri_chk u_rtpsri_chk (.*);

`default_nettype wire
